@@ design/chm_pkg.sv @@
// shared constants and types for the circular hanning mask
package chm_pkg;

    localparam int COORD_BITS       = 16;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int WEIGHT_W         = WEIGHT_FRAC_BITS + 1;
    localparam int OUT_SHIFT        = 31 - WEIGHT_FRAC_BITS;
    localparam int IN_DATA_W        = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W       = ((WEIGHT_W + 7) / 8) * 8;
    localparam int RAD_W            = 24;
    localparam int TAPER_W          = 17;
    localparam int CFG_DATA_W       = 24;
    localparam int ROOT_IN_W        = 48;
    localparam int SQ_STAGES        = 24;
    localparam int LQ_BITS          = 16;
    localparam int HORNER_N         = 7;

    localparam logic [16:0] Q16_ONE  = 17'h10000;
    localparam logic [31:0] Q30_ONE  = 32'h4000_0000;
    localparam logic [31:0] PI_Q30   = 32'd3373259426;

    localparam logic [7:0] HORNER_K [HORNER_N] = '{
        8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
    };
    // floor(2^32 / k), quotient estimate is low by at most one
    localparam logic [31:0] HORNER_M [HORNER_N] = '{
        32'((64'd1 << 32) / 182), 32'((64'd1 << 32) / 132), 32'((64'd1 << 32) / 90),
        32'((64'd1 << 32) / 56), 32'((64'd1 << 32) / 30), 32'((64'd1 << 32) / 12),
        32'((64'd1 << 32) / 2)
    };

    typedef enum logic [1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_RADIUS   = 2'd2,
        CFG_TAPER    = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic outside;
        logic flat;
    } t_side;

    typedef struct packed {
        logic outside;
        logic flat;
        logic upper;
    } t_flags;

endpackage

@@ design/circular_hanning_mask.sv @@
// top level: radial tukey apodization weight per pixel
// Takes one pixel coordinate per clock while the skid entry is empty and returns one
// weight per pixel in order. The pipeline holds distance squaring, a 24 stage square
// root, two 16 stage dividers for l and the taper position, and a 21 stage cosine
// evaluation with three stages per horner step. A stalled output holds one result and
// a skid entry holds a second; the whole pipeline pauses only while the skid entry is
// full.
module circular_hanning_mask import chm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // pixel_x, pixel_y
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // weight
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [COORD_BITS-1:0] r_center_x;
    logic [COORD_BITS-1:0] r_center_y;
    logic [RAD_W-1:0]      r_radius;
    logic [TAPER_W-1:0]    r_taper;
    logic [2*RAD_W-1:0]    r_rr;
    logic [TAPER_W-1:0]    r_t;
    logic                  en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_radius   <= RAD_W'(256);
            r_taper    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_CENTER_X: r_center_x <= i_cfg_data[COORD_BITS-1:0];
                CFG_CENTER_Y: r_center_y <= i_cfg_data[COORD_BITS-1:0];
                CFG_RADIUS:   r_radius   <= i_cfg_data[RAD_W-1:0];
                CFG_TAPER:    r_taper    <= i_cfg_data[TAPER_W-1:0];
                default: ;
            endcase
        end
    end

    // derived constants follow the registers in the next cycle
    always_ff @(posedge i_clk) begin
        r_rr <= r_radius * r_radius;
        r_t  <= (r_taper > Q16_ONE) ? Q16_ONE : r_taper;
    end

    // stage 1: absolute differences
    logic                  r_s1_v;
    logic [COORD_BITS-1:0] r_s1_dx, r_s1_dy;
    logic [COORD_BITS-1:0] px, py;
    assign px = i_s_tdata[COORD_BITS-1:0];
    assign py = i_s_tdata[2*COORD_BITS-1:COORD_BITS];

    // stage 2: squares
    logic                    r_s2_v;
    logic [2*COORD_BITS-1:0] r_s2_dx2, r_s2_dy2;

    // stage 3: sum and outside test
    logic                    r_s3_v;
    logic [ROOT_IN_W-1:0]    r_s3_rad;
    logic                    r_s3_out;
    logic [2*COORD_BITS:0]   d2;
    logic [63:0]             d2_wide;
    assign d2      = {1'b0, r_s2_dx2} + {1'b0, r_s2_dy2};
    assign d2_wide = 64'(d2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_s_tvalid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
        if (en) begin
            r_s1_dx  <= (px >= r_center_x) ? px - r_center_x : r_center_x - px;
            r_s1_dy  <= (py >= r_center_y) ? py - r_center_y : r_center_y - py;
            r_s2_dx2 <= r_s1_dx * r_s1_dx;
            r_s2_dy2 <= r_s1_dy * r_s1_dy;
            r_s3_rad <= {d2_wide[31:0], 16'b0};
            r_s3_out <= (d2_wide[63:32] != '0) || ({d2_wide[31:0], 16'b0} >= r_rr);
        end
    end

    logic                 sq_v;
    logic [SQ_STAGES-1:0] sq_root;
    t_side                sq_side;

    chm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s3_v),
        .i_rad   (r_s3_rad),
        .i_side  ('{outside: r_s3_out, flat: 1'b0}),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    logic               d1_v;
    logic [LQ_BITS-1:0] d1_quo;
    t_side              d1_side;

    chm_div u_div_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_v),
        .i_num   (RAD_W'(sq_root)),
        .i_div   (r_radius),
        .i_side  (sq_side),
        .o_valid (d1_v),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    // stage 4: flat part test and taper numerator
    logic               r_s4_v;
    logic [TAPER_W-1:0] r_s4_a;
    t_side              r_s4_side;
    logic [TAPER_W:0]   lt_sum;
    assign lt_sum = {2'b0, d1_quo} + {1'b0, r_t};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (en) begin
            r_s4_v <= d1_v;
        end
        if (en) begin
            r_s4_a            <= TAPER_W'(lt_sum - {1'b0, Q16_ONE});
            r_s4_side.outside <= d1_side.outside;
            r_s4_side.flat    <= !d1_side.outside && (lt_sum <= {1'b0, Q16_ONE});
        end
    end

    logic               d2_v;
    logic [LQ_BITS-1:0] d2_quo;
    t_side              d2_side;

    chm_div u_div_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s4_v),
        .i_num   (RAD_W'(r_s4_a)),
        .i_div   (RAD_W'(r_t)),
        .i_side  (r_s4_side),
        .o_valid (d2_v),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    // stage 5: fold u about one half and scale to radians
    logic               r_s5_v;
    logic [47:0]        r_s5_prod;
    t_flags             r_s5_f;
    logic               upper;
    logic [LQ_BITS-1:0] fold_v;
    assign upper  = d2_quo > 16'h8000;
    assign fold_v = upper ? LQ_BITS'(Q16_ONE - {1'b0, d2_quo}) : d2_quo;

    // stage 6: phi squared
    logic        r_s6_v;
    logic [63:0] r_s6_sq;
    t_flags      r_s6_f;
    logic [31:0] phi;
    assign phi = r_s5_prod[47:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
        end else if (en) begin
            r_s5_v <= d2_v;
            r_s6_v <= r_s5_v;
        end
        if (en) begin
            r_s5_prod <= fold_v * PI_Q30;
            r_s5_f    <= '{outside: d2_side.outside, flat: d2_side.flat, upper: upper};
            r_s6_sq   <= phi * phi;
            r_s6_f    <= r_s5_f;
        end
    end

    // horner steps, three stages each: product, reciprocal, correction
    logic [62:0] r_ha_prod [HORNER_N];
    logic [31:0] r_ha_x2   [HORNER_N];
    logic        r_ha_v    [HORNER_N];
    t_flags      r_ha_f    [HORNER_N];
    logic [63:0] r_hb_m    [HORNER_N];
    logic [31:0] r_hb_p    [HORNER_N];
    logic [31:0] r_hb_x2   [HORNER_N];
    logic        r_hb_v    [HORNER_N];
    t_flags      r_hb_f    [HORNER_N];
    logic [30:0] r_hc_acc  [HORNER_N];
    logic [31:0] r_hc_x2   [HORNER_N];
    logic        r_hc_v    [HORNER_N];
    t_flags      r_hc_f    [HORNER_N];

    for (genvar j = 0; j < HORNER_N; j++) begin : g_hor
        logic [31:0] w_x2;
        logic [30:0] w_acc;
        logic        w_v;
        t_flags      w_f;
        logic [31:0] w_p;
        logic [31:0] w_q0;
        logic [31:0] w_rr;
        logic [31:0] w_q;

        if (j == 0) begin : g_first
            assign w_x2  = r_s6_sq[61:30];
            assign w_acc = Q30_ONE[30:0];
            assign w_v   = r_s6_v;
            assign w_f   = r_s6_f;
        end else begin : g_next
            assign w_x2  = r_hc_x2[j-1];
            assign w_acc = r_hc_acc[j-1];
            assign w_v   = r_hc_v[j-1];
            assign w_f   = r_hc_f[j-1];
        end

        assign w_p  = r_ha_prod[j][61:30];
        assign w_q0 = r_hb_m[j][63:32];
        assign w_rr = r_hb_p[j] - 32'(w_q0 * HORNER_K[j]);
        assign w_q  = (w_rr >= 32'(HORNER_K[j])) ? w_q0 + 32'd1 : w_q0;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ha_v[j] <= 1'b0;
                r_hb_v[j] <= 1'b0;
                r_hc_v[j] <= 1'b0;
            end else if (en) begin
                r_ha_v[j] <= w_v;
                r_hb_v[j] <= r_ha_v[j];
                r_hc_v[j] <= r_hb_v[j];
            end
            if (en) begin
                r_ha_prod[j] <= w_x2 * w_acc;
                r_ha_x2[j]   <= w_x2;
                r_ha_f[j]    <= w_f;
                r_hb_m[j]    <= w_p * HORNER_M[j];
                r_hb_p[j]    <= w_p;
                r_hb_x2[j]   <= r_ha_x2[j];
                r_hb_f[j]    <= r_ha_f[j];
                r_hc_acc[j]  <= (w_q >= Q30_ONE) ? '0 : 31'(Q30_ONE - w_q);
                r_hc_x2[j]   <= r_hb_x2[j];
                r_hc_f[j]    <= r_hb_f[j];
            end
        end
    end

    // final stage: cos^2 from cos and weight select
    logic                r_fin_v;
    logic [WEIGHT_W-1:0] r_fin_w;
    t_flags              fin_f;
    logic [31:0]         cos_c;
    logic [31:0]         q31;
    logic [32:0]         q31_rnd;
    assign fin_f   = r_hc_f[HORNER_N-1];
    assign cos_c   = 32'(r_hc_acc[HORNER_N-1]);
    assign q31     = fin_f.upper ? Q30_ONE - cos_c : Q30_ONE + cos_c;
    assign q31_rnd = {1'b0, q31} + (33'd1 << (OUT_SHIFT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_v <= 1'b0;
        end else if (en) begin
            r_fin_v <= r_hc_v[HORNER_N-1];
        end
        if (en) begin
            if (fin_f.outside) begin
                r_fin_w <= '0;
            end else if (fin_f.flat) begin
                r_fin_w <= WEIGHT_W'(1) << WEIGHT_FRAC_BITS;
            end else begin
                r_fin_w <= WEIGHT_W'(q31_rnd >> OUT_SHIFT);
            end
        end
    end

    // output register with one skid entry
    logic                r_out_v, r_skid_v;
    logic [WEIGHT_W-1:0] r_out_w, r_skid_w;

    assign en = !r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_m_tready) begin
                r_out_w  <= r_skid_w;
                r_skid_v <= 1'b0;
            end
        end else if (r_out_v && !i_m_tready) begin
            if (r_fin_v) begin
                r_skid_w <= r_fin_w;
                r_skid_v <= 1'b1;
            end
        end else begin
            r_out_v <= r_fin_v;
            r_out_w <= r_fin_w;
        end
    end

    assign o_s_tready = en;
    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = OUT_DATA_W'(r_out_w);

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held without an output result");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hc_v[HORNER_N-1] |-> !(fin_f.outside && fin_f.flat))
        else $error("pixel marked both outside and flat");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out_w <= (WEIGHT_W'(1) << WEIGHT_FRAC_BITS)))
        else $error("weight above one");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_m_tready) |=> (!r_skid_v && r_out_v))
        else $error("skid entry not moved to output");
`endif

endmodule

@@ design/chm_sqrt.sv @@
// pipelined integer square root, one result bit per stage
module chm_sqrt import chm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [ROOT_IN_W-1:0] i_rad,
    input  t_side                i_side,
    output logic                 o_valid,
    output logic [SQ_STAGES-1:0] o_root,
    output t_side                o_side
);

    logic [ROOT_IN_W-1:0] r_n   [SQ_STAGES];
    logic [ROOT_IN_W-1:0] r_res [SQ_STAGES];
    logic                 r_v   [SQ_STAGES];
    t_side                r_side[SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
        localparam logic [ROOT_IN_W:0] BIT = (ROOT_IN_W + 1)'(1) << (ROOT_IN_W - 2 - 2 * k);
        logic [ROOT_IN_W-1:0] w_n;
        logic [ROOT_IN_W-1:0] w_res;
        logic                 w_v;
        t_side                w_side;
        logic [ROOT_IN_W:0]   w_sum;
        logic                 w_ge;

        if (k == 0) begin : g_first
            assign w_n    = i_rad;
            assign w_res  = '0;
            assign w_v    = i_valid;
            assign w_side = i_side;
        end else begin : g_next
            assign w_n    = r_n[k-1];
            assign w_res  = r_res[k-1];
            assign w_v    = r_v[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_sum = {1'b0, w_res} + BIT;
        assign w_ge  = {1'b0, w_n} >= w_sum;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
            if (i_en) begin
                r_n[k]    <= w_ge ? ROOT_IN_W'({1'b0, w_n} - w_sum) : w_n;
                r_res[k]  <= w_ge ? ROOT_IN_W'({1'b0, w_res >> 1} + BIT) : (w_res >> 1);
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_v[SQ_STAGES-1];
    assign o_root  = r_res[SQ_STAGES-1][SQ_STAGES-1:0];
    assign o_side  = r_side[SQ_STAGES-1];

endmodule

@@ design/chm_div.sv @@
// pipelined restoring divider for a fraction num/div below one
module chm_div import chm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [RAD_W-1:0]   i_num,
    input  logic [RAD_W-1:0]   i_div,
    input  t_side              i_side,
    output logic               o_valid,
    output logic [LQ_BITS-1:0] o_quo,
    output t_side              o_side
);

    logic [RAD_W-1:0]   r_rem [LQ_BITS];
    logic [LQ_BITS-1:0] r_quo [LQ_BITS];
    logic               r_v   [LQ_BITS];
    t_side              r_side[LQ_BITS];

    for (genvar k = 0; k < LQ_BITS; k++) begin : g_div
        logic [RAD_W-1:0]   w_rem;
        logic [LQ_BITS-1:0] w_quo;
        logic               w_v;
        t_side              w_side;
        logic [RAD_W:0]     w_rem2;
        logic               w_ge;

        if (k == 0) begin : g_first
            assign w_rem  = i_num;
            assign w_quo  = '0;
            assign w_v    = i_valid;
            assign w_side = i_side;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_quo  = r_quo[k-1];
            assign w_v    = r_v[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_rem2 = {w_rem, 1'b0};
        assign w_ge   = w_rem2 >= {1'b0, i_div};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
            if (i_en) begin
                r_rem[k]  <= w_ge ? RAD_W'(w_rem2 - {1'b0, i_div}) : RAD_W'(w_rem2);
                r_quo[k]  <= {w_quo[LQ_BITS-2:0], w_ge};
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_v[LQ_BITS-1];
    assign o_quo   = r_quo[LQ_BITS-1];
    assign o_side  = r_side[LQ_BITS-1];

endmodule

@@ dv/circular_hanning_mask_tb.sv @@
// testbench for the circular hanning mask: predicted weights checked against the stream
`timescale 1ns / 100ps

module circular_hanning_mask_tb;
    import chm_pkg::*;

    localparam int LATENCY    = 85;
    localparam int IDLE_LIMIT = 20000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;   // pixel_x, pixel_y
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;   // weight
    logic                  i_cfg_we;
    logic [1:0]            i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // predictor copy of the registers
    logic [15:0] ctr_x;
    logic [15:0] ctr_y;
    logic [23:0] radius;
    logic [16:0] taper;

    logic [WEIGHT_W-1:0] weight_q[$];
    int  n_err;
    int  n_in;
    int  n_out;
    int  idle_cnt;
    bit  rx_stall_on;

    circular_hanning_mask dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [WEIGHT_W-1:0] cos2_weight(longint unsigned u);
        bit upper;
        longint unsigned v, phi, x2, acc, sub, q31;
        upper = u > 32768;
        v = upper ? (65536 - u) : u;
        phi = (v * longint'(PI_Q30)) >> 16;
        x2 = (phi * phi) >> 30;
        acc = 64'd1 << 30;
        for (int k = 0; k < HORNER_N; k++) begin
            sub = ((x2 * acc) >> 30) / HORNER_K[k];
            acc = (sub >= (64'd1 << 30)) ? 0 : ((64'd1 << 30) - sub);
        end
        q31 = upper ? ((64'd1 << 30) - acc) : ((64'd1 << 30) + acc);
        return WEIGHT_W'((q31 + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT);
    endfunction

    function automatic logic [WEIGHT_W-1:0] mask_weight(logic [15:0] px, logic [15:0] py);
        longint unsigned dx, dy, d2, r, t, lq, u;
        dx = (px >= ctr_x) ? px - ctr_x : ctr_x - px;
        dy = (py >= ctr_y) ? py - ctr_y : ctr_y - py;
        d2 = dx * dx + dy * dy;
        r = radius;
        t = (taper > 65536) ? 65536 : taper;
        if (d2 >= (64'd1 << 32) || (d2 << 16) >= r * r) return '0;
        lq = (isqrt(d2 << 16) << 16) / r;
        if (lq + t <= 65536) return WEIGHT_W'(1 << WEIGHT_FRAC_BITS);
        u = ((lq + t - 65536) << 16) / t;
        return cos2_weight(u);
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (weight_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_CENTER_X: ctr_x  = val[15:0];
            CFG_CENTER_Y: ctr_y  = val[15:0];
            CFG_RADIUS:   radius = val[23:0];
            CFG_TAPER:    taper  = val[16:0];
            default: ;
        endcase
    endtask

    task automatic set_circle(logic [15:0] cx, logic [15:0] cy, logic [23:0] r,
                              logic [16:0] t);
        wait_drained();
        write_reg(CFG_CENTER_X, CFG_DATA_W'(cx));
        write_reg(CFG_CENTER_Y, CFG_DATA_W'(cy));
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_TAPER, CFG_DATA_W'(t));
        i_cfg_we <= 1'b0;
    endtask

    // sends one pixel; valid stays high across back-to-back transfers
    task automatic send_pixel(logic [15:0] px, logic [15:0] py, bit gaps = 1);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {py, px};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        weight_q.push_back(mask_weight(px, py));
        n_in++;
    endtask

    // pixel near the circle edge so the taper is hit often
    task automatic send_near_edge();
        int rr;
        real rp, a;
        longint sx, sy;
        rp = radius / 256.0;
        a = $urandom_range(0, 6283) / 1000.0;
        rr = $urandom_range(0, 1200);
        sx = longint'(ctr_x) + longint'(rp * rr / 1000.0 * $cos(a));
        sy = longint'(ctr_y) + longint'(rp * rr / 1000.0 * $sin(a));
        if (sx < 0) sx = 0;
        if (sx > 65535) sx = 65535;
        if (sy < 0) sy = 0;
        if (sy > 65535) sy = 65535;
        send_pixel(sx[15:0], sy[15:0]);
    endtask

    task automatic test_directed();
        set_circle(16'd100, 16'd100, 24'd2560, 17'd32768);
        send_pixel(16'd100, 16'd100, 0);
        send_pixel(16'd105, 16'd100, 0);
        send_pixel(16'd107, 16'd100, 0);
        send_pixel(16'd109, 16'd100, 0);
        send_pixel(16'd110, 16'd100, 0);
        send_pixel(16'd0, 16'd0, 0);
        send_pixel(16'hffff, 16'hffff, 0);
        // zero taper gives a hard step
        set_circle(16'd100, 16'd100, 24'd2560, 17'd0);
        send_pixel(16'd109, 16'd100, 0);
        send_pixel(16'd110, 16'd100, 0);
        // taper above one acts as one, also all-ones register value
        set_circle(16'd0, 16'd0, 24'd2560, 17'h1ffff);
        send_pixel(16'd3, 16'd4, 0);
        send_pixel(16'd0, 16'd0, 0);
        // zero radius, every pixel outside
        set_circle(16'd5, 16'd5, 24'd0, 17'd65536);
        send_pixel(16'd5, 16'd5, 0);
        // largest radius, far pixels
        set_circle(16'hffff, 16'hffff, 24'hffffff, 17'd65536);
        send_pixel(16'd0, 16'd0, 0);
        send_pixel(16'hffff, 16'hffff, 0);
        send_pixel(16'h8000, 16'h8000, 0);
        set_circle(16'd0, 16'hffff, 24'd1, 17'd1);
        send_pixel(16'd0, 16'hffff, 0);
        send_pixel(16'd1, 16'hffff, 0);
    endtask

    task automatic test_random_circles();
        for (int ph = 0; ph < 12; ph++) begin
            set_circle(16'($urandom), 16'($urandom),
                       (ph % 3 == 0) ? 24'($urandom) : 24'($urandom_range(256, 20 * 65536)),
                       (ph % 4 == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536)));
            for (int i = 0; i < 60; i++) begin
                if ($urandom_range(0, 4) == 0) send_pixel(16'($urandom), 16'($urandom));
                else send_near_edge();
            end
        end
    endtask

    task automatic test_back_to_back();
        set_circle(16'd2000, 16'd3000, 24'd25600, 17'd20000);
        for (int i = 0; i < 100; i++) send_near_edge();
        for (int i = 0; i < 20; i++) send_pixel(16'($urandom_range(1900, 2100)),
                                                16'($urandom_range(2900, 3100)), 0);
    endtask

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                n_out++;
                if (weight_q.size() == 0) begin
                    $display("%0t: unexpected weight %0d", $time, o_m_tdata[WEIGHT_W-1:0]);
                    n_err++;
                end else if (o_m_tdata[WEIGHT_W-1:0] !== weight_q[0]) begin
                    $display("%0t: weight mismatch expected %0d actual %0d", $time,
                             weight_q[0], o_m_tdata[WEIGHT_W-1:0]);
                    n_err++;
                    void'(weight_q.pop_front());
                end else begin
                    void'(weight_q.pop_front());
                end
            end
            if (rx_stall_on) i_m_tready <= (gap_len() == 0);
            else i_m_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_CENTER_X;
        i_cfg_data <= '0;
        n_err = 0;
        n_in = 0;
        n_out = 0;
        idle_cnt = 0;
        rx_stall_on = 1'b1;
        ctr_x = '0;
        ctr_y = '0;
        radius = 24'd256;
        taper = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // reset values of the registers
        send_pixel(16'd0, 16'd0, 0);
        send_pixel(16'd1, 16'd0, 0);
        test_directed();
        test_random_circles();
        rx_stall_on = 1'b0;
        test_back_to_back();
        rx_stall_on = 1'b1;
        test_random_circles();
        wait_drained();
        $display("covered %0d pixels and %0d weights over directed edge cases", n_in, n_out);
        $display("and randomized circles with tapers from hard step to full");
        if (n_err == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule

@@ circular_hanning_mask.f @@
design/chm_pkg.sv
design/chm_sqrt.sv
design/chm_div.sv
design/circular_hanning_mask.sv
dv/circular_hanning_mask_tb.sv
